// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl files that check themselves
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define CDB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cdb assertion failed");

// next-cycle implication, sampled on i_clk, off during reset
`define CDB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cdb assertion failed");

`endif

// File: rtl/core/cdb_pkg.sv
// types and codes shared by the circular deque buffer
package cdb_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DATA_W = 32;
    localparam int POS_W  = 8;
    localparam int REQ_W  = 3;
    localparam int CAP_W  = 9;
    localparam int STAT_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_READ       = 3'd4,
        REQ_ROTATE     = 3'd5,
        REQ_CLEAR      = 3'd6
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] write_value;
    } t_in_word;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic [STAT_W-1:0] status;
        logic [CAP_W-1:0]  entry_count;
        logic              is_empty;
        logic              is_full;
    } t_out_word;

    // outcome of one request, from the pointer control to the top level
    typedef struct packed {
        logic             rd_used;
        t_status          status;
        logic [CAP_W-1:0] count;
        logic             empty;
        logic             full;
    } t_op_result;

    // apb register index
    localparam logic REG_CAPACITY = 1'b0;

endpackage

// File: rtl/core/circular_deque_buffer_top.sv
// circular deque buffer top level: handshakes, apb register, slot ram and output register
//
// double-ended ring buffer of up to 256 32-bit entries, the ring length set
// by the capacity register (apb byte address 0, 1..256, reset 256; writing it
// empties the buffer). each input word carries one
// request: push back, push front, pop front, pop back, read at an index from
// the head, rotate, or clear; a push onto a full buffer drops the opposite end.
// every request returns exactly one output word with the value read or popped
// (zero otherwise), a status code, the entry count and the empty/full flags.
// the request is decoded and pointers, count, any slot write and the
// registered read of the slot ram are committed at the edge the word is
// accepted; a new word is not taken until the result has moved into the
// output register (as soon as that register is free). the output register
// lets a new word be accepted while the previous result still waits. the
// slot ram has no reset and no clearing pass; reading a slot that was never
// written returns whatever it holds.
`include "assert_macros.svh"

module circular_deque_buffer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cdb_pkg::t_in_word             i_in_word,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cdb_pkg::t_out_word            o_out_word,
    // apb configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int AW = cdb_pkg::ADDR_W;

    // one-hot sequencer: idle takes a word, done waits for the output register to be free
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DONE = 2'b10
    } t_state;

    t_state                    r_state, n_state;
    logic                      in_acc, out_free, cfg_we;
    cdb_pkg::t_op_result       result;
    cdb_pkg::t_op_result       r_pend;
    logic [cdb_pkg::CAP_W-1:0] cap;
    logic                      ram_we, ram_re;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    logic [cdb_pkg::DATA_W-1:0] ram_rdata;
    logic                      r_out_valid;
    cdb_pkg::t_out_word        r_out_word;
    logic                      out_err;

    // handshakes
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;
    // output register is empty or its word leaves this edge
    assign out_free   = ~r_out_valid | i_out_ready;

    // apb: always ready, single register at index 0
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & (paddr[2] == cdb_pkg::REG_CAPACITY);
    assign prdata = (paddr[2] == cdb_pkg::REG_CAPACITY) ? 32'(cap) : '0;

    // pointer and count control, commits on accept
    cdb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (in_acc),
        .i_word      (i_in_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (pwdata[cdb_pkg::CAP_W-1:0]),
        .o_result    (result),
        .o_cap       (cap),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr)
    );

    // slot store; read data holds until the next read enable
    cdb_ram #(
        .WIDTH (cdb_pkg::DATA_W),
        .DEPTH (cdb_pkg::DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in_word.write_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state: only one request in flight, so a read never meets a write
    // to the same slot in the same cycle
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request outcome held while the ram read completes
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pend <= result;
        end
    end

    // output register load
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_word.read_value  <= r_pend.rd_used ? ram_rdata : '0;
            r_out_word.status      <= r_pend.status;
            r_out_word.entry_count <= r_pend.count;
            r_out_word.is_empty    <= r_pend.empty;
            r_out_word.is_full     <= r_pend.full;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // result word on the bus carries an error status
    assign out_err = o_out_valid & (o_out_word.status != cdb_pkg::ST_OK);

    // assertions
    // count after any request stays within the ring
    `CDB_ASSERT_NOW(a_count_in_cap, in_acc, result.count <= cap)
    // a failed request never returns data
    `CDB_ASSERT_NOW(a_fail_no_data, out_err, o_out_word.read_value == '0)
    // capacity is at least one, so empty and full never show together
    `CDB_ASSERT_NOW(a_flags_excl, o_out_valid, !(o_out_word.is_empty && o_out_word.is_full))
    // interlock: no second word while the slot read is outstanding
    `CDB_ASSERT_NEXT(a_one_in_flight, in_acc, !o_in_ready)

endmodule

// File: rtl/core/cdb_ram.sv
// generic simple dual-port ram with registered, enabled read
module cdb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/cdb_ctrl.sv
// head, tail, count and capacity registers with the per-request update logic
module cdb_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  cdb_pkg::t_in_word             i_word,
    input  logic                          i_cfg_we,
    input  logic [cdb_pkg::CAP_W-1:0]     i_cfg_data,
    output cdb_pkg::t_op_result           o_result,
    output logic [cdb_pkg::CAP_W-1:0]     o_cap,
    output logic                          o_ram_we,
    output logic [cdb_pkg::ADDR_W-1:0]    o_ram_waddr,
    output logic                          o_ram_re,
    output logic [cdb_pkg::ADDR_W-1:0]    o_ram_raddr
);

    localparam int DEPTH  = cdb_pkg::DEPTH;
    localparam int AW     = cdb_pkg::ADDR_W;
    localparam int SW     = ((AW > cdb_pkg::CAP_W) ? AW : cdb_pkg::CAP_W) + 1;
    localparam int CapRst = (DEPTH < 256) ? DEPTH : 256;

    logic [AW-1:0]             r_head, r_tail;
    logic [cdb_pkg::CAP_W-1:0] r_count, r_cap;
    logic [SW-1:0]             n_head, n_tail;
    logic [cdb_pkg::CAP_W-1:0] n_count, cap_in;
    logic [SW-1:0]             cap_x, head_x, tail_x;
    logic                      full, empty, pos_bad;
    cdb_pkg::t_status          status;
    logic                      rd_used, we, re;
    logic [SW-1:0]             waddr, raddr;

    function automatic logic [SW-1:0] f_inc(input logic [SW-1:0] p, input logic [SW-1:0] c);
        logic [SW-1:0] s;
        s = p + SW'(1);
        return (s >= c) ? '0 : s;
    endfunction

    function automatic logic [SW-1:0] f_dec(input logic [SW-1:0] p, input logic [SW-1:0] c);
        return (p == '0) ? (c - SW'(1)) : (p - SW'(1));
    endfunction

    function automatic logic [SW-1:0] f_add(input logic [SW-1:0] p,
                                            input logic [SW-1:0] k,
                                            input logic [SW-1:0] c);
        logic [SW-1:0] s;
        s = p + k;
        return (s >= c) ? (s - c) : s;
    endfunction

    assign cap_x   = SW'(r_cap);
    assign head_x  = SW'(r_head);
    assign tail_x  = SW'(r_tail);
    assign full    = (r_count >= r_cap);
    assign empty   = (r_count == '0);
    assign pos_bad = ({1'b0, i_word.position} >= r_count);

    always_comb begin
        n_head  = head_x;
        n_tail  = tail_x;
        n_count = r_count;
        status  = cdb_pkg::ST_OK;
        rd_used = 1'b0;
        we      = 1'b0;
        re      = 1'b0;
        waddr   = tail_x;
        raddr   = head_x;
        unique case (i_word.req_type)
            cdb_pkg::REQ_PUSH_BACK: begin
                if (full) begin
                    n_head = f_inc(head_x, cap_x);
                end else begin
                    n_count = r_count + 1'b1;
                end
                we     = 1'b1;
                waddr  = tail_x;
                n_tail = f_inc(tail_x, cap_x);
            end
            cdb_pkg::REQ_PUSH_FRONT: begin
                if (full) begin
                    n_tail = f_dec(tail_x, cap_x);
                end else begin
                    n_count = r_count + 1'b1;
                end
                n_head = f_dec(head_x, cap_x);
                we     = 1'b1;
                waddr  = n_head;
            end
            cdb_pkg::REQ_POP_FRONT: begin
                if (empty) begin
                    status = cdb_pkg::ST_EMPTY;
                end else begin
                    re      = 1'b1;
                    rd_used = 1'b1;
                    raddr   = head_x;
                    n_head  = f_inc(head_x, cap_x);
                    n_count = r_count - 1'b1;
                end
            end
            cdb_pkg::REQ_POP_BACK: begin
                if (empty) begin
                    status = cdb_pkg::ST_EMPTY;
                end else begin
                    n_tail  = f_dec(tail_x, cap_x);
                    re      = 1'b1;
                    rd_used = 1'b1;
                    raddr   = n_tail;
                    n_count = r_count - 1'b1;
                end
            end
            cdb_pkg::REQ_READ: begin
                if (pos_bad) begin
                    status = cdb_pkg::ST_RANGE;
                end else begin
                    re      = 1'b1;
                    rd_used = 1'b1;
                    raddr   = f_add(head_x, SW'(i_word.position), cap_x);
                end
            end
            cdb_pkg::REQ_ROTATE: begin
                if (pos_bad) begin
                    status = cdb_pkg::ST_RANGE;
                end else begin
                    n_head = f_add(head_x, SW'(i_word.position), cap_x);
                    n_tail = f_add(tail_x, SW'(i_word.position), cap_x);
                end
            end
            cdb_pkg::REQ_CLEAR: begin
                if (empty) begin
                    status = cdb_pkg::ST_EMPTY;
                end else begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                end
            end
            default: begin
                // unused request code: no operation
            end
        endcase
    end

    // capacity write saturates into 1..DEPTH
    always_comb begin
        cap_in = i_cfg_data;
        if (i_cfg_data == '0) begin
            cap_in = cdb_pkg::CAP_W'(1);
        end else if (32'(i_cfg_data) > 32'(DEPTH)) begin
            cap_in = cdb_pkg::CAP_W'(DEPTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_cap   <= cdb_pkg::CAP_W'(CapRst);
        end else if (i_cfg_we) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_cap   <= cap_in;
        end else if (i_go) begin
            r_head  <= AW'(n_head);
            r_tail  <= AW'(n_tail);
            r_count <= n_count;
        end
    end

    assign o_result.rd_used = rd_used;
    assign o_result.status  = status;
    assign o_result.count   = n_count;
    assign o_result.empty   = (n_count == '0);
    assign o_result.full    = (n_count == r_cap);

    assign o_cap       = r_cap;
    assign o_ram_we    = i_go & we;
    assign o_ram_waddr = AW'(waddr);
    assign o_ram_re    = i_go & re;
    assign o_ram_raddr = AW'(raddr);

endmodule
